// ----- sv/scq_pkg.sv -----
// shared types, constants and helper functions for the sprite cell color quantizer
package scq_pkg;

   // recolor table and color field widths
   localparam int RECOLOR_PAIRS = 4;
   localparam int RGB_W         = 24;
   localparam int PAIR_W        = 2 * RGB_W;
   localparam int GLYPH_W       = 32;
   localparam int INDEX_W       = 8;
   localparam int COUNT_W       = 3;

   // configuration port
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = PAIR_W;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RECOLOR_COUNT  = 3'd0,
      CSR_RECOLOR_PAIR_0 = 3'd1,
      CSR_RECOLOR_PAIR_1 = 3'd2,
      CSR_RECOLOR_PAIR_2 = 3'd3,
      CSR_RECOLOR_PAIR_3 = 3'd4
   } csr_index_type;

   // queue between front and back
   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW      = QUEUE_AW + 1;

   // color encoding constants
   localparam logic [RGB_W-1:0]   MAGENTA_RGB       = 24'hFF00FF;
   localparam logic [INDEX_W-1:0] TRANSPARENT_INDEX = 8'hFF;
   localparam logic [INDEX_W-1:0] HEIGHT_UNDEFINED  = 8'hFF;
   localparam int CUBE_BASE      = 16;
   localparam int RED_WEIGHT     = 36;
   localparam int GREEN_WEIGHT   = 6;
   localparam int QUANT_MUL      = 5;
   localparam int QUANT_ROUND    = 128;
   localparam int QUANT_DIV_STD  = 255;
   localparam int QUANT_DIV_REFL = 400;
   localparam int QUANT_LEVELS   = 5;
   localparam int QUANT_SUM_W    = 11;

   // height glyph character codes
   localparam logic [GLYPH_W-1:0] GLYPH_DIGIT_0 = 32'h30;
   localparam logic [GLYPH_W-1:0] GLYPH_DIGIT_9 = 32'h39;
   localparam logic [GLYPH_W-1:0] GLYPH_UPPER_A = 32'h41;
   localparam logic [GLYPH_W-1:0] GLYPH_UPPER_Z = 32'h5A;
   localparam int HEIGHT_LETTER_BASE = 10;

   // input transaction
   typedef struct packed {
      logic [GLYPH_W-1:0] image_glyph;
      logic [RGB_W-1:0]   fore_rgb;
      logic [RGB_W-1:0]   back_rgb;
      logic [RGB_W-1:0]   key_rgb;
      logic [GLYPH_W-1:0] height_glyph;
      logic               reflection;
   } req_type;

   // result transaction
   typedef struct packed {
      logic [GLYPH_W-1:0] out_glyph;
      logic [INDEX_W-1:0] fore_index;
      logic [INDEX_W-1:0] back_index;
      logic [INDEX_W-1:0] height_code;
   } rsp_type;

   // classified cell held in the queue
   typedef struct packed {
      logic [GLYPH_W-1:0] glyph;
      logic [RGB_W-1:0]   fore_rgb;
      logic [RGB_W-1:0]   back_rgb;
      logic               fore_transparent;
      logic               back_transparent;
      logic               reflection;
      logic [INDEX_W-1:0] height_code;
   } work_type;

   // recolor configuration seen by the front
   typedef struct packed {
      logic [COUNT_W-1:0]                  count;
      logic [RECOLOR_PAIRS-1:0][PAIR_W-1:0] pair;
   } recolor_cfg_type;

   // quantize one 8-bit channel as (c*5+128)/div by threshold compares
   function automatic logic [2:0] quant_channel(input logic [7:0] c, input logic reflection);
      logic [QUANT_SUM_W-1:0] v;
      int                     div;
      logic [2:0]             q;
      v   = QUANT_SUM_W'(c) * QUANT_SUM_W'(QUANT_MUL) + QUANT_SUM_W'(QUANT_ROUND);
      div = reflection ? QUANT_DIV_REFL : QUANT_DIV_STD;
      q   = 3'd0;
      for (int k = 1; k <= QUANT_LEVELS; k++) begin
         if (int'(v) >= k * div) begin
            q = 3'(k);
         end
      end
      return q;
   endfunction

   // color cube index 16 + 36r + 6g + b
   function automatic logic [INDEX_W-1:0] encode_rgb(input logic [RGB_W-1:0] rgb,
                                                     input logic reflection);
      logic [2:0] r;
      logic [2:0] g;
      logic [2:0] b;
      r = quant_channel(rgb[23:16], reflection);
      g = quant_channel(rgb[15:8], reflection);
      b = quant_channel(rgb[7:0], reflection);
      return INDEX_W'(CUBE_BASE + RED_WEIGHT * int'(r) + GREEN_WEIGHT * int'(g) + int'(b));
   endfunction

endpackage

// ----- sv/scq_front.sv -----
// front end: transparency test, height decode and recolor chain for one cell
module scq_front
   import scq_pkg::*;
(
   input  req_type         req_data,
   input  recolor_cfg_type recolor_cfg,
   output work_type        work_data
);

   logic [RGB_W-1:0]   fore_recolored;
   logic [RGB_W-1:0]   back_recolored;
   logic [INDEX_W-1:0] height_code;
   logic               magenta_back;

   // recolor chain, pairs applied in order so matches can chain
   always_comb begin
      fore_recolored = req_data.fore_rgb;
      back_recolored = req_data.back_rgb;
      for (int i = 0; i < RECOLOR_PAIRS; i++) begin
         if (i < int'(recolor_cfg.count)) begin
            if (fore_recolored == recolor_cfg.pair[i][PAIR_W-1:RGB_W]) begin
               fore_recolored = recolor_cfg.pair[i][RGB_W-1:0];
            end
            if (back_recolored == recolor_cfg.pair[i][PAIR_W-1:RGB_W]) begin
               back_recolored = recolor_cfg.pair[i][RGB_W-1:0];
            end
         end
      end
   end

   // height glyph decode
   always_comb begin
      if (req_data.height_glyph inside {[GLYPH_DIGIT_0:GLYPH_DIGIT_9]}) begin
         height_code = INDEX_W'(req_data.height_glyph - GLYPH_DIGIT_0);
      end else if (req_data.height_glyph inside {[GLYPH_UPPER_A:GLYPH_UPPER_Z]}) begin
         height_code = INDEX_W'(req_data.height_glyph - GLYPH_UPPER_A)
                       + INDEX_W'(HEIGHT_LETTER_BASE);
      end else begin
         height_code = HEIGHT_UNDEFINED;
      end
   end

   // transparency uses the colors as they arrive
   assign magenta_back = (req_data.back_rgb == MAGENTA_RGB);

   always_comb begin
      work_data.glyph            = req_data.image_glyph;
      work_data.fore_rgb         = fore_recolored;
      work_data.back_rgb         = back_recolored;
      work_data.fore_transparent = magenta_back || (req_data.fore_rgb == req_data.key_rgb);
      work_data.back_transparent = magenta_back || (req_data.back_rgb == req_data.key_rgb);
      work_data.reflection       = req_data.reflection;
      work_data.height_code      = height_code;
   end

endmodule

// ----- sv/scq_queue.sv -----
// short queue of classified cells between the front and the back
module scq_queue
   import scq_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_data,
   output logic     full,
   output logic     pop_valid,
   input  logic     pop,
   output work_type pop_data
);

   work_type            mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff;
   logic [QUEUE_AW-1:0] wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff;
   logic [QUEUE_AW-1:0] rd_ptr_in;
   logic [QUEUE_CW-1:0] count_ff;
   logic [QUEUE_CW-1:0] count_in;

   // storage write
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff + QUEUE_CW'(push) - QUEUE_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign full      = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   // fill count stays within the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CW'(QUEUE_DEPTH))
      else $error("queue fill count above depth");

   // no push into a full queue, no pop from an empty one
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full) && !(pop && !pop_valid))
      else $error("queue overflow or underflow");

   // pointer distance matches the fill count
   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff == QUEUE_CW'(QUEUE_DEPTH)) || (QUEUE_AW'(wr_ptr_ff - rd_ptr_ff) == count_ff[QUEUE_AW-1:0]))
      else $error("queue pointers disagree with fill count");

endmodule

// ----- sv/scq_back.sv -----
// back end: channel quantization, cube index and output register
module scq_back
   import scq_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     work_valid,
   input  work_type work_data,
   output logic     work_pop,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   logic    out_valid_ff;
   logic    out_valid_in;
   rsp_type out_data_ff;
   rsp_type out_data_in;
   logic    out_free;

   // output register free when empty or being taken this cycle
   assign out_free = !out_valid_ff || !rsp_stall;
   assign work_pop = work_valid && out_free;

   // encode both colors of the cell
   always_comb begin
      out_data_in.out_glyph   = work_data.glyph;
      out_data_in.fore_index  = work_data.fore_transparent ? TRANSPARENT_INDEX
                                : encode_rgb(work_data.fore_rgb, work_data.reflection);
      out_data_in.back_index  = work_data.back_transparent ? TRANSPARENT_INDEX
                                : encode_rgb(work_data.back_rgb, work_data.reflection);
      out_data_in.height_code = work_data.height_code;
      out_valid_in            = work_pop || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (work_pop) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // foreground index is transparent or inside the color cube
   a_fore_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.fore_index == TRANSPARENT_INDEX)
                    || (rsp_data.fore_index >= 8'd16 && rsp_data.fore_index <= 8'd231))
      else $error("foreground index outside color cube");

   // background index is transparent or inside the color cube
   a_back_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.back_index == TRANSPARENT_INDEX)
                    || (rsp_data.back_index >= 8'd16 && rsp_data.back_index <= 8'd231))
      else $error("background index outside color cube");

   // a pop only happens when the output slot frees up, so a popped cell always reaches the output register
   a_pop_slot: assert property (@(posedge clock) disable iff (reset)
      work_pop |=> rsp_valid)
      else $error("popped cell did not reach the output register");

endmodule

// ----- sv/sprite_cell_color_quantizer_top.sv -----
// Sprite cell color quantizer: converts one sprite cell per transaction into a terminal cell
// with xterm cube color indexes and a decoded height. It takes one cell every clock cycle while
// req_stall is low and presents its result after the cell passes the queue and the output register:
// the front classifies the cell and runs the recolor chain into a four-entry queue, and the back
// quantizes both colors into an output register. req_stall rises only when the queue is full, which
// happens when the result side has stalled long enough. Recolor registers must be written through the
// csr port only while the block is idle; the block does not enforce it. Writes to unknown indexes are ignored.
module sprite_cell_color_quantizer_top
   import scq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   recolor_cfg_type recolor_cfg_ff;
   recolor_cfg_type recolor_cfg_in;
   work_type        front_work;
   work_type        queue_work;
   logic            queue_full;
   logic            queue_valid;
   logic            queue_pop;
   logic            req_accept;

   // configuration register writes
   always_comb begin
      recolor_cfg_in = recolor_cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_RECOLOR_COUNT: begin
               recolor_cfg_in.count = csr_data[COUNT_W-1:0];
            end
            CSR_RECOLOR_PAIR_0, CSR_RECOLOR_PAIR_1,
            CSR_RECOLOR_PAIR_2, CSR_RECOLOR_PAIR_3: begin
               for (int i = 0; i < RECOLOR_PAIRS; i++) begin
                  if (csr_index == CSR_INDEX_W'(int'(CSR_RECOLOR_PAIR_0) + i)) begin
                     recolor_cfg_in.pair[i] = csr_data[PAIR_W-1:0];
                  end
               end
            end
            default: begin
               recolor_cfg_in = recolor_cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recolor_cfg_ff <= '0;
      end else begin
         recolor_cfg_ff <= recolor_cfg_in;
      end
   end

   // input transaction handshake
   assign req_stall  = queue_full;
   assign req_accept = req_valid && !queue_full;

   scq_front u_front (
      .req_data    (req_data),
      .recolor_cfg (recolor_cfg_ff),
      .work_data   (front_work)
   );

   scq_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (front_work),
      .full      (queue_full),
      .pop_valid (queue_valid),
      .pop       (queue_pop),
      .pop_data  (queue_work)
   );

   scq_back u_back (
      .clock      (clock),
      .reset      (reset),
      .work_valid (queue_valid),
      .work_data  (queue_work),
      .work_pop   (queue_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
